>>> rtl/mbg_pkg.sv
// Shared constants and controller/datapath interface types for the maze generator.
`timescale 1ns / 1ps
`default_nettype none
package mbg_pkg;

  localparam int COLS_DEF = 80;
  localparam int ROWS_DEF = 61;

  localparam int COL_W     = 7;
  localparam int ROW_W     = 6;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;

  localparam int S_TDATA_W = 8;
  localparam int S_TUSER_W = 1;
  localparam int M_TDATA_W = 16;
  localparam int M_TUSER_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_COLS_USED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_USED = 1'b1;

  localparam logic [COL_W-1:0] COLS_USED_RST = 7'd80;
  localparam logic [ROW_W-1:0] ROWS_USED_RST = 6'd61;

  localparam logic CMD_STEP    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_UP    = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  localparam logic [2:0] MARK_FREE = 3'd0;
  localparam logic [2:0] MARK_ROOT = 3'd5;
  localparam logic [2:0] MARK_DONE = 3'd6;

  localparam logic [1:0] EV_CARVE   = 2'd0;
  localparam logic [1:0] EV_BACK    = 2'd1;
  localparam logic [1:0] EV_FIN     = 2'd2;
  localparam logic [1:0] EV_RESTART = 2'd3;

  typedef struct packed {
    logic step_start;
    logic restart;
    logic rd_nb;
    logic rd_self;
    logic try_adv;
    logic carve;
    logic back;
    logic finish;
    logic fin_hold;
    logic clr_start;
    logic clr_step;
    logic emit;
  } mbg_cmd_t;

  typedef struct packed {
    logic nb_ok;
    logic nb_free;
    logic last_try;
    logic back_ok;
    logic finished;
    logic clr_last;
    logic out_busy;
  } mbg_stat_t;

endpackage
`default_nettype wire

>>> rtl/mbg_ctrl.sv
// Controller state machine that sequences probes, backtracks and grid clearing.
`timescale 1ns / 1ps
`default_nettype none
module mbg_ctrl (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic                             cmd_code,
  input  wire mbg_pkg::mbg_stat_t               stat,
  output mbg_pkg::mbg_cmd_t                     cmd
);
  import mbg_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_PROBE  = 7'b0000100,
    S_CHECK  = 7'b0001000,
    S_SELF   = 7'b0010000,
    S_DECIDE = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   clear_emit, clear_emit_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clear_emit <= 1'b0;
    end else begin
      state      <= state_next;
      clear_emit <= clear_emit_next;
    end
  end

  always_comb begin
    state_next      = state;
    clear_emit_next = clear_emit;
    cmd             = '0;
    s_tready        = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next      = clear_emit ? S_EMIT : S_IDLE;
          clear_emit_next = 1'b0;
        end
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (cmd_code == CMD_RESTART) begin
            cmd.restart     = 1'b1;
            cmd.clr_start   = 1'b1;
            clear_emit_next = 1'b1;
            state_next      = S_CLEAR;
          end else if (stat.finished) begin
            cmd.fin_hold = 1'b1;
            state_next   = S_EMIT;
          end else begin
            cmd.step_start = 1'b1;
            state_next     = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        // skip off-grid neighbors without a memory read
        if (stat.nb_ok) begin
          cmd.rd_nb  = 1'b1;
          state_next = S_CHECK;
        end else if (stat.last_try) begin
          state_next = S_SELF;
        end else begin
          cmd.try_adv = 1'b1;
        end
      end
      S_CHECK: begin
        if (stat.nb_free) begin
          cmd.carve  = 1'b1;
          state_next = S_EMIT;
        end else if (stat.last_try) begin
          state_next = S_SELF;
        end else begin
          cmd.try_adv = 1'b1;
          state_next  = S_PROBE;
        end
      end
      S_SELF: begin
        cmd.rd_self = 1'b1;
        state_next  = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.back_ok) begin
          cmd.back = 1'b1;
        end else begin
          cmd.finish = 1'b1;
        end
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/mbg_datapath.sv
// Datapath: cell mark memory, position registers, neighbor logic and output register.
`timescale 1ns / 1ps
`default_nettype none
module mbg_datapath #(
  parameter int COLS = mbg_pkg::COLS_DEF,
  parameter int ROWS = mbg_pkg::ROWS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [mbg_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [mbg_pkg::CFG_W-1:0]        cfg_data,
  input  wire logic [1:0]                       start_dir,
  input  wire mbg_pkg::mbg_cmd_t                cmd,
  output mbg_pkg::mbg_stat_t                    stat,
  input  wire logic                             m_tready,
  output logic                                  m_tvalid,
  output logic [mbg_pkg::M_TDATA_W-1:0]         m_tdata,
  output logic [mbg_pkg::M_TUSER_W-1:0]         m_tuser
);
  import mbg_pkg::*;

  localparam int NCELL = COLS * ROWS;
  localparam int CW    = $clog2(COLS);
  localparam int RW    = $clog2(ROWS);
  localparam int AW    = $clog2(NCELL);
  localparam int CDW   = ((CW > COL_W) ? CW : COL_W) + 1;
  localparam int RDW   = ((RW > ROW_W) ? RW : ROW_W) + 1;

  logic [COL_W-1:0] cols_used;
  logic [ROW_W-1:0] rows_used;
  logic [CW-1:0]    cur_col;
  logic [RW-1:0]    cur_row;
  logic [AW-1:0]    cur_idx;
  logic             finished;
  logic [1:0]       try_dir;
  logic [1:0]       try_num;
  logic [AW-1:0]    clr_addr;
  logic [2:0]       rd_data;
  logic [1:0]       res_ev;
  logic [1:0]       res_mdir;

  logic [2:0]       marks [NCELL];

  logic [CDW-1:0]   cu, cw_lim, col_ext, nb_col, par_col;
  logic [RDW-1:0]   ru, rh_lim, row_ext, nb_row, par_row;
  logic             nb_lo, par_ok, is_entry;
  logic [AW-1:0]    nb_idx, par_idx;
  logic [1:0]       bk_k;

  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [2:0]       wdata;

  // Usable grid size, saturated to 1..COLS and 1..ROWS
  always_comb begin
    cu      = CDW'(cols_used);
    ru      = RDW'(rows_used);
    cw_lim  = (cu == '0) ? CDW'(1) : ((cu > CDW'(COLS)) ? CDW'(COLS) : cu);
    rh_lim  = (ru == '0) ? RDW'(1) : ((ru > RDW'(ROWS)) ? RDW'(ROWS) : ru);
    col_ext = CDW'(cur_col);
    row_ext = RDW'(cur_row);
  end

  // Neighbor in the direction under trial
  always_comb begin
    nb_col = col_ext;
    nb_row = row_ext;
    nb_lo  = 1'b1;
    nb_idx = cur_idx;
    case (try_dir)
      DIR_RIGHT: begin
        nb_col = col_ext + CDW'(1);
        nb_idx = cur_idx + AW'(1);
      end
      DIR_UP: begin
        nb_row = row_ext - RDW'(1);
        nb_lo  = (cur_row != '0);
        nb_idx = cur_idx - AW'(COLS);
      end
      DIR_LEFT: begin
        nb_col = col_ext - CDW'(1);
        nb_lo  = (cur_col != '0);
        nb_idx = cur_idx - AW'(1);
      end
      DIR_DOWN: begin
        nb_row = row_ext + RDW'(1);
        nb_idx = cur_idx + AW'(COLS);
      end
      default: begin
        nb_lo = 1'b0;
      end
    endcase
  end

  // Parent cell from the entry mark; step back against the entry direction
  always_comb begin
    is_entry = (rd_data >= 3'd1) && (rd_data <= 3'd4);
    bk_k     = 2'(rd_data - 3'd1);
    par_col  = col_ext;
    par_row  = row_ext;
    par_ok   = 1'b0;
    par_idx  = cur_idx;
    case (bk_k)
      DIR_RIGHT: begin
        par_col = col_ext - CDW'(1);
        par_ok  = (cur_col != '0);
        par_idx = cur_idx - AW'(1);
      end
      DIR_UP: begin
        par_row = row_ext + RDW'(1);
        par_ok  = (par_row < RDW'(ROWS));
        par_idx = cur_idx + AW'(COLS);
      end
      DIR_LEFT: begin
        par_col = col_ext + CDW'(1);
        par_ok  = (par_col < CDW'(COLS));
        par_idx = cur_idx + AW'(1);
      end
      DIR_DOWN: begin
        par_row = row_ext - RDW'(1);
        par_ok  = (cur_row != '0);
        par_idx = cur_idx - AW'(COLS);
      end
      default: begin
        par_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    stat.nb_ok    = nb_lo && (nb_col < cw_lim) && (nb_row < rh_lim);
    stat.nb_free  = (rd_data == MARK_FREE);
    stat.last_try = (try_num == 2'd3);
    stat.back_ok  = is_entry && par_ok;
    stat.finished = finished;
    stat.clr_last = (clr_addr == AW'(NCELL - 1));
    stat.out_busy = m_tvalid && !m_tready;
  end

  // Memory port selection
  always_comb begin
    we    = 1'b0;
    waddr = cur_idx;
    wdata = MARK_DONE;
    if (cmd.clr_step) begin
      we    = 1'b1;
      waddr = clr_addr;
      wdata = (clr_addr == '0) ? MARK_ROOT : MARK_FREE;
    end else if (cmd.carve) begin
      we    = 1'b1;
      waddr = nb_idx;
      wdata = 3'(try_dir) + 3'd1;
    end else if (cmd.back || cmd.finish) begin
      we = 1'b1;
    end
    raddr = cmd.rd_nb ? nb_idx : cur_idx;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      marks[waddr] <= wdata;
    end
    if (cmd.rd_nb || cmd.rd_self) begin
      rd_data <= marks[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_used <= COLS_USED_RST;
      rows_used <= ROWS_USED_RST;
      cur_col   <= '0;
      cur_row   <= '0;
      cur_idx   <= '0;
      finished  <= 1'b0;
      try_dir   <= '0;
      try_num   <= '0;
      clr_addr  <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_COLS_USED: cols_used <= cfg_data;
          REG_ROWS_USED: rows_used <= cfg_data[ROW_W-1:0];
          default: ;
        endcase
      end
      if (cmd.step_start) begin
        try_dir <= start_dir;
        try_num <= '0;
      end else if (cmd.try_adv) begin
        try_dir <= try_dir + 2'd1;
        try_num <= try_num + 2'd1;
      end
      if (cmd.restart) begin
        cur_col  <= '0;
        cur_row  <= '0;
        cur_idx  <= '0;
        finished <= 1'b0;
      end else if (cmd.carve) begin
        cur_col <= nb_col[CW-1:0];
        cur_row <= nb_row[RW-1:0];
        cur_idx <= nb_idx;
      end else if (cmd.back) begin
        cur_col <= par_col[CW-1:0];
        cur_row <= par_row[RW-1:0];
        cur_idx <= par_idx;
      end else if (cmd.finish) begin
        finished <= 1'b1;
      end
      if (cmd.clr_start) begin
        clr_addr <= '0;
      end else if (cmd.clr_step) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.restart) begin
      res_ev   <= EV_RESTART;
      res_mdir <= DIR_RIGHT;
    end else if (cmd.carve) begin
      res_ev   <= EV_CARVE;
      res_mdir <= try_dir;
    end else if (cmd.back) begin
      res_ev   <= EV_BACK;
      res_mdir <= bk_k + 2'd2;
    end else if (cmd.finish || cmd.fin_hold) begin
      res_ev   <= EV_FIN;
      res_mdir <= DIR_RIGHT;
    end
    if (cmd.emit) begin
      m_tdata <= M_TDATA_W'({res_mdir, ROW_W'(cur_row), COL_W'(cur_col)});
      m_tuser <= res_ev;
    end
  end

endmodule
`default_nettype wire

>>> rtl/maze_backtracker_generator_unit.sv
// Top level of the stackless depth-first maze generator.
// Step item: one memory read per in-grid neighbor probe, one more for the cell's own mark when
//   no neighbor is free (backtrack or finish); no read once the walk has finished.
// Restart item: a clearing pass over all COLS*ROWS cells (4880 by default), then the result.
// One item in work at a time; a waiting result holds the next result, not the next accept.
// Reset (rst, synchronous): clears control state and registers, then clears the grid.
`timescale 1ns / 1ps
`default_nettype none
module maze_backtracker_generator_unit #(
  parameter int COLS = mbg_pkg::COLS_DEF,
  parameter int ROWS = mbg_pkg::ROWS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [mbg_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [mbg_pkg::CFG_W-1:0]        cfg_data,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [mbg_pkg::S_TDATA_W-1:0]    s_tdata,  // [1:0] start_dir
  input  wire logic [mbg_pkg::S_TUSER_W-1:0]    s_tuser,  // [0] cmd
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [mbg_pkg::M_TDATA_W-1:0]         m_tdata,  // [6:0] cell_col, [12:7] cell_row,
                                                          // [14:13] move_dir
  output logic [mbg_pkg::M_TUSER_W-1:0]         m_tuser   // [1:0] event_res
);
  import mbg_pkg::*;

  mbg_cmd_t  cmd;
  mbg_stat_t stat;

  mbg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd_code (s_tuser[0]),
    .stat     (stat),
    .cmd      (cmd)
  );

  mbg_datapath #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .start_dir (s_tdata[1:0]),
    .cmd       (cmd),
    .stat      (stat),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule
`default_nettype wire

>>> rtl/mbg_checker.sv
// Port-level assertions for the maze generator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module mbg_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             s_tvalid,
  input wire logic                             s_tready,
  input wire logic                             m_tvalid,
  input wire logic                             m_tready,
  input wire logic [mbg_pkg::M_TDATA_W-1:0]    m_tdata,
  input wire logic [mbg_pkg::M_TUSER_W-1:0]    m_tuser
);
  import mbg_pkg::*;

  // Reset starts the clearing pass: nothing offered, nothing taken
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid && !s_tready)
    else $error("output valid or input ready right after reset");

  // One item in work at a time
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready again right after an accepted item");

  // A restart always lands on cell 0,0 with no move
  a_restart_home: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == EV_RESTART) |-> (m_tdata[14:0] == 15'd0))
    else $error("restart result not at cell 0,0");

  a_fin_no_move: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == EV_FIN) |-> (m_tdata[14:13] == DIR_RIGHT))
    else $error("finished result carries a move direction");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed or dropped");

endmodule

bind maze_backtracker_generator_unit mbg_checker u_mbg_checker (.*);
`default_nettype wire

>>> tb/maze_walk_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the maze generator: predicts every walk step and checks each result.
module maze_walk_checker
  import mbg_pkg::*;
#(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [1:0] start_dir
  input  logic [S_TUSER_W-1:0] s_tuser,   // [0] cmd
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [M_TDATA_W-1:0] m_tdata,   // [6:0] cell_col, [12:7] cell_row, [14:13] move_dir
  input  logic [M_TUSER_W-1:0] m_tuser,   // [1:0] event_res
  output int                   errors,
  output int                   pending
);

  typedef struct packed {
    logic [1:0]       ev;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [1:0]       dir;
  } walk_result_t;

  logic [2:0]       cell_marks [COLS*ROWS];
  int               walk_col;
  int               walk_row;
  bit               walk_done;
  logic [COL_W-1:0] cols_used;
  logic [ROW_W-1:0] rows_used;
  walk_result_t     due_steps [$];

  function automatic int col_step(logic [1:0] d);
    case (d)
      DIR_RIGHT: return 1;
      DIR_LEFT:  return -1;
      default:   return 0;
    endcase
  endfunction

  function automatic int row_step(logic [1:0] d);
    case (d)
      DIR_UP:   return -1;
      DIR_DOWN: return 1;
      default:  return 0;
    endcase
  endfunction

  function automatic int clamp_dim(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void clear_walk();
    foreach (cell_marks[i]) cell_marks[i] = MARK_FREE;
    cell_marks[0] = MARK_ROOT;
    walk_col = 0;
    walk_row = 0;
    walk_done = 1'b0;
  endfunction

  function automatic walk_result_t take_walk_step(logic cmd, logic [1:0] first_dir);
    walk_result_t res;
    int           cw;
    int           rh;
    int           nc;
    int           nr;
    int           idx;
    logic [1:0]   k;
    logic [2:0]   mark;
    bit           moved;
    res.ev = EV_FIN;
    res.dir = '0;
    moved = 1'b0;
    if (cmd == CMD_RESTART) begin
      clear_walk();
      res.ev = EV_RESTART;
    end else if (!walk_done) begin
      cw = clamp_dim(cols_used, COLS);
      rh = clamp_dim(rows_used, ROWS);
      for (int t = 0; t < 4 && !moved; t++) begin
        k = first_dir + 2'(t);
        nc = walk_col + col_step(k);
        nr = walk_row + row_step(k);
        if (nc >= 0 && nr >= 0 && nc < cw && nr < rh) begin
          if (cell_marks[nr*COLS + nc] == MARK_FREE) begin
            // entry mark is the carve direction plus one
            cell_marks[nr*COLS + nc] = {1'b0, k} + 3'd1;
            walk_col = nc;
            walk_row = nr;
            res.ev = EV_CARVE;
            res.dir = k;
            moved = 1'b1;
          end
        end
      end
      if (!moved) begin
        idx = walk_row*COLS + walk_col;
        mark = cell_marks[idx];
        if (mark != MARK_FREE && mark < MARK_ROOT) begin
          k = 2'(mark - 3'd1);
          nc = walk_col - col_step(k);
          nr = walk_row - row_step(k);
          if (nc >= 0 && nr >= 0 && nc < COLS && nr < ROWS) begin
            cell_marks[idx] = MARK_DONE;
            walk_col = nc;
            walk_row = nr;
            res.ev = EV_BACK;
            res.dir = k + 2'd2;
            moved = 1'b1;
          end
        end
        // root or a broken mark ends the walk
        if (!moved) begin
          cell_marks[idx] = MARK_DONE;
          walk_done = 1'b1;
        end
      end
    end
    res.col = walk_col[COL_W-1:0];
    res.row = walk_row[ROW_W-1:0];
    return res;
  endfunction

  task automatic report_error(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) report_error($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  always @(posedge clk) begin : watch
    walk_result_t got;
    walk_result_t want;
    if (rst) begin
      due_steps.delete();
      cols_used = COLS_USED_RST;
      rows_used = ROWS_USED_RST;
      clear_walk();
    end else begin
      if (cfg_we) begin
        if (cfg_idx == REG_COLS_USED) cols_used = cfg_data[COL_W-1:0];
        else rows_used = cfg_data[ROW_W-1:0];
      end
      if (s_tvalid && s_tready) due_steps.push_back(take_walk_step(s_tuser[0], s_tdata[1:0]));
      if (m_tvalid && m_tready) begin
        got = {m_tuser[1:0], m_tdata[6:0], m_tdata[12:7], m_tdata[14:13]};
        if (due_steps.size() == 0) begin
          report_error("result with no step due");
        end else begin
          want = due_steps.pop_front();
          check_field("event_res", got.ev, want.ev);
          check_field("cell_col", got.col, want.col);
          check_field("cell_row", got.row, want.row);
          check_field("move_dir", got.dir, want.dir);
        end
      end
    end
    pending = due_steps.size();
  end

endmodule

>>> tb/maze_backtracker_generator_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for the maze generator: clock, reset, stimulus, receiver stalls and verdict.
module maze_backtracker_generator_unit_tb;
  import mbg_pkg::*;

  localparam int IDLE_LIMIT   = 20000;
  localparam int RANDOM_ITEMS = 1450;
  localparam int HOLD_CYCLES  = 400;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [S_TUSER_W-1:0] s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [M_TUSER_W-1:0] m_tuser;

  int errors;
  int pending;
  int items_sent = 0;
  int hold_reqs = 0;
  int idle_cycles = 0;
  bit no_gaps = 1'b0;

  always #5 clk = ~clk;

  maze_backtracker_generator_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  maze_walk_checker #(.COLS(COLS_DEF), .ROWS(ROWS_DEF)) walk_check (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .errors   (errors),
    .pending  (pending)
  );

  // mostly none or short, now and then long
  function automatic int pick_stall();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int span(int v, int hi);
    return (v < 1) ? 1 : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [CFG_W-1:0] pick_cols();
    int r;
    r = $urandom_range(0, 19);
    if (r < 15) return CFG_W'($urandom_range(2, 9));
    case (r)
      15:      return CFG_W'(0);
      16:      return CFG_W'(1);
      17:      return CFG_W'(COLS_DEF);
      18:      return CFG_W'(127);
      default: return CFG_W'($urandom_range(0, 127));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_rows();
    int r;
    r = $urandom_range(0, 19);
    if (r < 15) return CFG_W'($urandom_range(2, 8));
    case (r)
      15:      return CFG_W'(0);
      16:      return CFG_W'(1);
      17:      return CFG_W'(ROWS_DEF);
      18:      return CFG_W'(63);
      default: return CFG_W'($urandom_range(0, 63));
    endcase
  endfunction

  task automatic offer_item(logic cmd, logic [1:0] dir);
    int gap;
    gap = no_gaps ? 0 : pick_stall();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= S_TDATA_W'(dir);
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // drop valid and hold until every result is back
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // receiver: random stalls, stretches of constant ready, long hold-offs on request
  initial begin : receiver
    int hold_left;
    int stall_left;
    int served;
    int mode_left;
    bit eager;
    hold_left = 0;
    stall_left = 0;
    served = 0;
    mode_left = 0;
    eager = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != served) begin
        served++;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        eager = ($urandom_range(0, 3) == 0);
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!eager && $urandom_range(0, 2) == 0) begin
        stall_left = pick_stall();
        m_tready <= (stall_left == 0);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("maze_backtracker_generator_unit_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int               target;
    int               n;
    int               cells;
    int               phase;
    bit               pressure;
    logic [CFG_W-1:0] cols_now;
    logic [CFG_W-1:0] rows_now;
    cols_now = CFG_W'(COLS_USED_RST);
    rows_now = CFG_W'(ROWS_USED_RST);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // first moves from the root on the full grid, one per direction
    offer_item(CMD_STEP, DIR_RIGHT);
    offer_item(CMD_STEP, DIR_UP);
    offer_item(CMD_STEP, DIR_LEFT);
    offer_item(CMD_STEP, DIR_DOWN);
    offer_item(CMD_RESTART, DIR_DOWN);

    // smallest legal grid: walk to the finish and step past it
    settle();
    write_reg(REG_COLS_USED, CFG_W'(2));
    write_reg(REG_ROWS_USED, CFG_W'(2));
    offer_item(CMD_RESTART, DIR_UP);
    repeat (8) offer_item(CMD_STEP, 2'($urandom_range(0, 3)));

    // zero sizes count as one cell: the root finishes at once
    settle();
    write_reg(REG_COLS_USED, CFG_W'(0));
    write_reg(REG_ROWS_USED, CFG_W'(0));
    offer_item(CMD_RESTART, DIR_RIGHT);
    offer_item(CMD_STEP, DIR_RIGHT);
    offer_item(CMD_STEP, DIR_DOWN);

    // oversized values saturate; change them on a finished walk first
    settle();
    write_reg(REG_COLS_USED, CFG_W'(127));
    write_reg(REG_ROWS_USED, CFG_W'(63));
    cols_now = CFG_W'(127);
    rows_now = CFG_W'(63);
    offer_item(CMD_STEP, DIR_UP);
    offer_item(CMD_RESTART, DIR_LEFT);
    offer_item(CMD_STEP, DIR_LEFT);
    offer_item(CMD_STEP, DIR_UP);
    offer_item(CMD_STEP, DIR_DOWN);

    target = items_sent + RANDOM_ITEMS;
    phase = 0;
    while (items_sent < target) begin
      settle();
      pressure = (phase == 2 || phase == 17);
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 3) != 0) begin
          cols_now = pick_cols();
          write_reg(REG_COLS_USED, cols_now);
        end
        if ($urandom_range(0, 3) != 0) begin
          rows_now = pick_rows();
          write_reg(REG_ROWS_USED, rows_now);
        end
      end
      // keep the walk going under new sizes now and then
      if (!pressure && $urandom_range(0, 9) < 7) offer_item(CMD_RESTART, 2'($urandom_range(0, 3)));
      no_gaps = ($urandom_range(0, 3) == 0);
      if (pressure) hold_reqs++;
      cells = span(cols_now, COLS_DEF) * span(rows_now, ROWS_DEF);
      n = $urandom_range(cells, 2 * cells + 4);
      if (n > 80) n = $urandom_range(40, 80);
      repeat (n) begin
        offer_item(($urandom_range(0, 49) == 0) ? CMD_RESTART : CMD_STEP,
                   2'($urandom_range(0, 3)));
      end
      phase++;
    end

    settle();
    repeat (40) @(negedge clk);
    if (errors == 0) begin
      $display("maze_backtracker_generator_unit_tb passed");
    end else begin
      $display("maze_backtracker_generator_unit_tb failed");
    end
    $finish;
  end

endmodule
